// File: rtl/core/hrw_pkg.sv
// shared types, sequencer step codes and limits for the huber residual weighting core
// no dependencies; every other file but hrw_if refers to it by scoped names
package hrw_pkg;

    // point counter width and saturation limit
    localparam int unsigned CNT_W = 20;
    localparam logic [CNT_W-1:0] MAX_POINTS = 20'd524288;

    // sequencer step codes, in execution order
    localparam logic [5:0] OP_IDLE    = 6'd0;
    localparam logic [5:0] OP_PZ2     = 6'd1;
    localparam logic [5:0] OP_DEN_LO  = 6'd2;
    localparam logic [5:0] OP_DEN_HI  = 6'd3;
    localparam logic [5:0] OP_N0A     = 6'd4;
    localparam logic [5:0] OP_N0B     = 6'd5;
    localparam logic [5:0] OP_N1A     = 6'd6;
    localparam logic [5:0] OP_N1B     = 6'd7;
    localparam logic [5:0] OP_G0_INIT = 6'd8;
    localparam logic [5:0] OP_G0_DIV  = 6'd9;
    localparam logic [5:0] OP_G0_DONE = 6'd10;
    localparam logic [5:0] OP_G1_INIT = 6'd11;
    localparam logic [5:0] OP_G1_DIV  = 6'd12;
    localparam logic [5:0] OP_G1_DONE = 6'd13;
    localparam logic [5:0] OP_SL_A    = 6'd14;
    localparam logic [5:0] OP_SL_B    = 6'd15;
    localparam logic [5:0] OP_SQ      = 6'd16;
    localparam logic [5:0] OP_DD      = 6'd17;
    localparam logic [5:0] OP_S       = 6'd18;
    localparam logic [5:0] OP_T_LO    = 6'd19;
    localparam logic [5:0] OP_T_HI    = 6'd20;
    localparam logic [5:0] OP_DENOM   = 6'd21;
    localparam logic [5:0] OP_W_INIT  = 6'd22;
    localparam logic [5:0] OP_W_DIV   = 6'd23;
    localparam logic [5:0] OP_W_DONE  = 6'd24;
    localparam logic [5:0] OP_RT_INIT = 6'd25;
    localparam logic [5:0] OP_RT_STEP = 6'd26;
    localparam logic [5:0] OP_WRP     = 6'd27;
    localparam logic [5:0] OP_H_INIT  = 6'd28;
    localparam logic [5:0] OP_H_DIV   = 6'd29;
    localparam logic [5:0] OP_H_DONE  = 6'd30;
    localparam logic [5:0] OP_PW      = 6'd31;
    localparam logic [5:0] OP_RR      = 6'd32;
    localparam logic [5:0] OP_E_LO    = 6'd33;
    localparam logic [5:0] OP_E_HI    = 6'd34;
    localparam logic [5:0] OP_ACC     = 6'd35;
    localparam logic [5:0] OP_M_INIT  = 6'd36;
    localparam logic [5:0] OP_M_DIV   = 6'd37;
    localparam logic [5:0] OP_M_DONE  = 6'd38;
    localparam logic [5:0] OP_OUT     = 6'd39;

    typedef logic [5:0] t_op;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic out_busy;
    } t_sts;

    // configuration registers
    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic [31:0]        vgain;
        logic [31:0]        hwidth;
        logic [31:0]        noise;
    } t_cfg;

    // one input beat
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [30:0]        inv_depth;
        logic signed [31:0] residual;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic [30:0]        depth_variance;
        logic               last_point;
    } t_item;

    // one result beat
    typedef struct packed {
        logic [31:0] point_weight;
        logic [31:0] mean_error;
        logic        set_done;
    } t_res;

endpackage

// File: rtl/core/hrw_if.sv
// valid/ready channel interfaces for point input and weight output
// no dependencies
interface hrw_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [30:0]        inv_depth;
    logic signed [31:0] residual;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic [30:0]        depth_variance;
    logic               last_point;

    modport source (output valid, point_x, point_y, point_z, inv_depth, residual,
                    grad_x, grad_y, depth_variance, last_point, input ready);
    modport sink (input valid, point_x, point_y, point_z, inv_depth, residual,
                  grad_x, grad_y, depth_variance, last_point, output ready);
endinterface

interface hrw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_weight;
    logic [31:0] mean_error;
    logic        set_done;

    modport source (output valid, point_weight, mean_error, set_done, input ready);
    modport sink (input valid, point_weight, mean_error, set_done, output ready);
endinterface

// File: rtl/core/huber_residual_weighting_core.sv
// top level of the huber residual weighting core: apb registers, sequencer, datapath
// depends on hrw_pkg, hrw_if, hrw_cfg, hrw_ctrl, hrw_datapath
//
// usage:
//   i_in carries one warped tracking point per beat (valid/ready); o_out returns
//   one beat per point with the combined weight, and on a point flagged last
//   also the set's mean weighted squared error and set_done.
//   translation, variance gain, huber width and pixel noise sit in apb registers
//   at byte offsets 0x00..0x14; write them only while no point is in flight.
//   one point is taken at a time: the next point is accepted only once the
//   sequencer is back in idle, after the bit-serial divider (31, 31, 32, 17 and
//   32 steps; the last only on a set's last point) and the 24-step square root
//   sharing one sequencer have run for the previous point.
//   the result sits in an output register, so the next point is accepted
//   while the previous result waits; a stalled receiver holds the sequencer
//   at its output step until the register frees.
//   synchronous reset clears registers to their defaults, empties the set
//   accumulator and drops any pending result.
module huber_residual_weighting_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrw_in_if.sink            i_in,
    hrw_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    hrw_pkg::t_cfg  w_cfg;
    hrw_pkg::t_cmd  w_cmd;
    hrw_pkg::t_sts  w_sts;
    hrw_pkg::t_item w_item;
    hrw_pkg::t_res  w_res;
    logic           w_in_ready;
    logic           w_out_valid;

    assign pready = 1'b1;

    // input beat payload
    assign w_item.point_x        = i_in.point_x;
    assign w_item.point_y        = i_in.point_y;
    assign w_item.point_z        = i_in.point_z;
    assign w_item.inv_depth      = i_in.inv_depth;
    assign w_item.residual       = i_in.residual;
    assign w_item.grad_x         = i_in.grad_x;
    assign w_item.grad_y         = i_in.grad_y;
    assign w_item.depth_variance = i_in.depth_variance;
    assign w_item.last_point     = i_in.last_point;
    assign i_in.ready            = w_in_ready;

    hrw_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    hrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    hrw_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (w_item),
        .i_cfg       (w_cfg),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_res       (w_res)
    );

    // output beat
    assign o_out.valid        = w_out_valid;
    assign o_out.point_weight = w_res.point_weight;
    assign o_out.mean_error   = w_res.mean_error;
    assign o_out.set_done     = w_res.set_done;

endmodule

// File: rtl/core/hrw_cfg.sv
// apb register bank for translation, variance gain, huber width and pixel noise
// depends on hrw_pkg
module hrw_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output hrw_pkg::t_cfg      o_cfg
);

    localparam logic [2:0] REG_TX     = 3'd0;
    localparam logic [2:0] REG_TY     = 3'd1;
    localparam logic [2:0] REG_TZ     = 3'd2;
    localparam logic [2:0] REG_VGAIN  = 3'd3;
    localparam logic [2:0] REG_HWIDTH = 3'd4;
    localparam logic [2:0] REG_NOISE  = 3'd5;

    hrw_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign wr_en = i_psel && i_penable && i_pwrite;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tx     <= '0;
            r_cfg.ty     <= '0;
            r_cfg.tz     <= '0;
            r_cfg.vgain  <= 32'd65536;
            r_cfg.hwidth <= 32'd655360;
            r_cfg.noise  <= 32'd65536;
        end else if (wr_en) begin
            case (i_paddr[4:2])
                REG_TX:     r_cfg.tx     <= i_pwdata;
                REG_TY:     r_cfg.ty     <= i_pwdata;
                REG_TZ:     r_cfg.tz     <= i_pwdata;
                REG_VGAIN:  r_cfg.vgain  <= i_pwdata;
                REG_HWIDTH: r_cfg.hwidth <= i_pwdata;
                REG_NOISE:  r_cfg.noise  <= i_pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (i_paddr[4:2])
            REG_TX:     o_prdata = r_cfg.tx;
            REG_TY:     o_prdata = r_cfg.ty;
            REG_TZ:     o_prdata = r_cfg.tz;
            REG_VGAIN:  o_prdata = r_cfg.vgain;
            REG_HWIDTH: o_prdata = r_cfg.hwidth;
            REG_NOISE:  o_prdata = r_cfg.noise;
            default:    o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/hrw_datapath.sv
// datapath: shared 33x33 multiplier, restoring divider, bit-pair square root,
// set accumulator and output register; depends on hrw_pkg
module hrw_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrw_pkg::t_cmd   i_cmd,
    input  hrw_pkg::t_item  i_item,
    input  hrw_pkg::t_cfg   i_cfg,
    input  logic            i_out_ready,
    output hrw_pkg::t_sts   o_sts,
    output logic            o_out_valid,
    output hrw_pkg::t_res   o_res
);

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // latched point
    logic signed [31:0] r_px, r_py, r_pz, r_rp, r_gx, r_gy;
    logic [30:0]        r_d, r_var;
    logic               r_last;

    // intermediate results
    logic [63:0]        r_p;
    logic [95:0]        r_den;
    logic [95:0]        r_acc;
    logic signed [63:0] r_num0, r_num1, r_slope;
    logic signed [31:0] r_g0, r_g1;
    logic [31:0]        r_sq, r_s, r_wp, r_pw, r_mean;
    logic [63:0]        r_dd, r_denom, r_rr;
    logic [47:0]        r_sx;
    logic [25:0]        r_srem;
    logic [23:0]        r_root;
    logic [39:0]        r_wrp;
    logic [16:0]        r_wh;

    // divider state
    logic [127:0]       r_rem, r_dsh;
    logic [31:0]        r_q;
    logic               r_sat, r_neg, r_nz, r_hlt;

    // set state and output
    logic [63:0]                 r_esum;
    logic [hrw_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_ovalid;
    hrw_pkg::t_res               r_res;

    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p;
    logic [63:0]        m64;
    logic [31:0]        pz_mag, rmag, gval0, gval1;
    logic [63:0]        mag0, mag1, smag, term;
    logic [64:0]        dsum, esum_sum;
    logic [30:0]        h;
    logic [27:0]        rt_rem2, rt_trial;
    logic               out_busy;

    assign pz_mag   = abs32(r_pz);
    assign rmag     = abs32(r_rp);
    assign mag0     = abs64(r_num0);
    assign mag1     = abs64(r_num1);
    assign smag     = abs64(r_slope);
    assign h        = i_cfg.hwidth[31:1];
    assign out_busy = r_ovalid && !i_out_ready;
    assign term     = r_acc[95:32];
    assign dsum     = {1'b0, r_acc[95:32]} + {33'd0, i_cfg.noise};
    assign esum_sum = {1'b0, r_esum} + {1'b0, term};
    assign rt_rem2  = {r_srem, r_sx[47:46]};
    assign rt_trial = {2'b00, r_root, 2'b01};
    assign gval0    = r_sat ? 32'h7FFF_FFFF : {1'b0, r_q[30:0]};
    assign gval1    = gval0;

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            hrw_pkg::OP_PZ2: begin
                m_a = {1'b0, pz_mag};
                m_b = {1'b0, pz_mag};
            end
            hrw_pkg::OP_DEN_LO: begin
                m_a = {1'b0, r_p[31:0]};
                m_b = {2'b00, r_d};
            end
            hrw_pkg::OP_DEN_HI: begin
                m_a = {1'b0, r_p[63:32]};
                m_b = {2'b00, r_d};
            end
            hrw_pkg::OP_N0A: begin
                m_a = {i_cfg.tx[31], i_cfg.tx};
                m_b = {r_pz[31], r_pz};
            end
            hrw_pkg::OP_N0B: begin
                m_a = {i_cfg.tz[31], i_cfg.tz};
                m_b = {r_px[31], r_px};
            end
            hrw_pkg::OP_N1A: begin
                m_a = {i_cfg.ty[31], i_cfg.ty};
                m_b = {r_pz[31], r_pz};
            end
            hrw_pkg::OP_N1B: begin
                m_a = {i_cfg.tz[31], i_cfg.tz};
                m_b = {r_py[31], r_py};
            end
            hrw_pkg::OP_SL_A: begin
                m_a = {r_gx[31], r_gx};
                m_b = {r_g0[31], r_g0};
            end
            hrw_pkg::OP_SL_B: begin
                m_a = {r_gy[31], r_gy};
                m_b = {r_g1[31], r_g1};
            end
            hrw_pkg::OP_DD: begin
                m_a = {1'b0, r_sq};
                m_b = {1'b0, r_sq};
            end
            hrw_pkg::OP_S: begin
                m_a = {1'b0, i_cfg.vgain};
                m_b = {2'b00, r_var};
            end
            hrw_pkg::OP_T_LO: begin
                m_a = {1'b0, r_dd[31:0]};
                m_b = {1'b0, r_s};
            end
            hrw_pkg::OP_T_HI: begin
                m_a = {1'b0, r_dd[63:32]};
                m_b = {1'b0, r_s};
            end
            hrw_pkg::OP_WRP: begin
                m_a = {1'b0, rmag};
                m_b = {9'd0, r_root};
            end
            hrw_pkg::OP_PW: begin
                m_a = {16'd0, r_wh};
                m_b = {1'b0, r_wp};
            end
            hrw_pkg::OP_RR: begin
                m_a = {1'b0, rmag};
                m_b = {1'b0, rmag};
            end
            hrw_pkg::OP_E_LO: begin
                m_a = {1'b0, r_rr[31:0]};
                m_b = {1'b0, r_pw};
            end
            hrw_pkg::OP_E_HI: begin
                m_a = {1'b0, r_rr[63:32]};
                m_b = {1'b0, r_pw};
            end
            default: ;
        endcase
    end

    assign m_p = m_a * m_b;
    assign m64 = m_p[63:0];

    // datapath registers, one step per cycle while the output step is not held by a busy result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_item.point_x;
            r_py   <= i_item.point_y;
            r_pz   <= i_item.point_z;
            r_d    <= i_item.inv_depth;
            r_rp   <= i_item.residual;
            r_gx   <= i_item.grad_x;
            r_gy   <= i_item.grad_y;
            r_var  <= i_item.depth_variance;
            r_last <= i_item.last_point;
        end
        case (i_cmd.op)
            hrw_pkg::OP_PZ2:    r_p <= m64;
            hrw_pkg::OP_DEN_LO: r_acc <= {32'd0, m64};
            hrw_pkg::OP_DEN_HI: r_den <= r_acc + {m64, 32'd0};
            hrw_pkg::OP_N0A:    r_num0 <= m64;
            hrw_pkg::OP_N0B:    r_num0 <= r_num0 - m64;
            hrw_pkg::OP_N1A:    r_num1 <= m64;
            hrw_pkg::OP_N1B:    r_num1 <= r_num1 - m64;
            // warp slope divisions, saturating at +-(2^31-1)
            hrw_pkg::OP_G0_INIT: begin
                r_rem <= {32'd0, mag0, 32'd0};
                r_dsh <= {2'b00, r_den, 30'd0};
                r_sat <= ({32'd0, mag0, 32'd0} >= {1'b0, r_den, 31'd0});
                r_neg <= r_num0[63];
                r_nz  <= (mag0 != 64'd0);
                r_q   <= '0;
            end
            hrw_pkg::OP_G1_INIT: begin
                r_rem <= {32'd0, mag1, 32'd0};
                r_dsh <= {2'b00, r_den, 30'd0};
                r_sat <= ({32'd0, mag1, 32'd0} >= {1'b0, r_den, 31'd0});
                r_neg <= r_num1[63];
                r_nz  <= (mag1 != 64'd0);
                r_q   <= '0;
            end
            hrw_pkg::OP_G0_DIV, hrw_pkg::OP_G1_DIV, hrw_pkg::OP_W_DIV,
            hrw_pkg::OP_H_DIV, hrw_pkg::OP_M_DIV: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
            end
            hrw_pkg::OP_G0_DONE: begin
                if (!r_nz) r_g0 <= '0;
                else r_g0 <= r_neg ? (~gval0 + 32'd1) : gval0;
            end
            hrw_pkg::OP_G1_DONE: begin
                if (!r_nz) r_g1 <= '0;
                else r_g1 <= r_neg ? (~gval1 + 32'd1) : gval1;
            end
            hrw_pkg::OP_SL_A: r_slope <= m64;
            hrw_pkg::OP_SL_B: r_slope <= r_slope + m64;
            hrw_pkg::OP_SQ:   r_sq <= (|smag[63:48]) ? 32'hFFFF_FFFF : smag[47:16];
            hrw_pkg::OP_DD:   r_dd <= m64;
            hrw_pkg::OP_S:    r_s <= (|m64[63:48]) ? 32'hFFFF_FFFF : m64[47:16];
            hrw_pkg::OP_T_LO: r_acc <= {32'd0, m64};
            hrw_pkg::OP_T_HI: r_acc <= r_acc + {m64, 32'd0};
            hrw_pkg::OP_DENOM: r_denom <= dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];
            // variance weight 2^32 / denom
            hrw_pkg::OP_W_INIT: begin
                r_rem <= {95'd0, 1'b1, 32'd0};
                r_dsh <= {33'd0, r_denom, 31'd0};
                r_sat <= (r_denom[63:1] == 63'd0);
                r_q   <= '0;
            end
            hrw_pkg::OP_W_DONE: r_wp <= r_sat ? 32'hFFFF_FFFF : r_q;
            // square root of w in q16.16, two bits per step
            hrw_pkg::OP_RT_INIT: begin
                r_sx   <= {r_wp, 16'd0};
                r_srem <= '0;
                r_root <= '0;
            end
            hrw_pkg::OP_RT_STEP: begin
                if (rt_rem2 >= rt_trial) begin
                    r_srem <= 26'(rt_rem2 - rt_trial);
                    r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_srem <= 26'(rt_rem2);
                    r_root <= {r_root[22:0], 1'b0};
                end
                r_sx <= {r_sx[45:0], 2'b00};
            end
            hrw_pkg::OP_WRP: r_wrp <= m64[55:16];
            // huber factor (h << 16) / e
            hrw_pkg::OP_H_INIT: begin
                r_rem <= {81'd0, h, 16'd0};
                r_dsh <= {72'd0, r_wrp, 16'd0};
                r_hlt <= ({9'd0, h} > r_wrp);
                r_nz  <= (r_wrp != 40'd0);
                r_q   <= '0;
            end
            hrw_pkg::OP_H_DONE: begin
                if (r_hlt) r_wh <= 17'h10000;
                else if (!r_nz) r_wh <= '0;
                else r_wh <= r_q[16:0];
            end
            hrw_pkg::OP_PW:   r_pw <= m64[47:16];
            hrw_pkg::OP_RR:   r_rr <= m64;
            hrw_pkg::OP_E_LO: r_acc <= {32'd0, m64};
            hrw_pkg::OP_E_HI: r_acc <= r_acc + {m64, 32'd0};
            hrw_pkg::OP_ACC:  r_mean <= '0;
            // set mean, saturating at 2^32-1
            hrw_pkg::OP_M_INIT: begin
                r_rem <= {64'd0, r_esum};
                r_dsh <= {77'd0, r_cnt, 31'd0};
                r_sat <= (r_esum[63:32] >= {12'd0, r_cnt});
                r_q   <= '0;
            end
            hrw_pkg::OP_M_DONE: r_mean <= r_sat ? 32'hFFFF_FFFF : r_q;
            hrw_pkg::OP_OUT: begin
                if (!out_busy) begin
                    r_res.point_weight <= r_pw;
                    r_res.mean_error   <= r_mean;
                    r_res.set_done     <= r_last;
                end
            end
            default: ;
        endcase
    end

    // set accumulator and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esum   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == hrw_pkg::OP_ACC) begin
                r_esum <= esum_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : esum_sum[63:0];
                if (r_cnt < hrw_pkg::MAX_POINTS) r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.op == hrw_pkg::OP_M_DONE) begin
                r_esum <= '0;
                r_cnt  <= '0;
            end
            if (i_cmd.op == hrw_pkg::OP_OUT && !out_busy) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_busy = out_busy;
    assign o_out_valid    = r_ovalid;
    assign o_res          = r_res;

endmodule

// File: rtl/core/hrw_ctrl.sv
// sequencer: steps the datapath through one point, counts divider and root steps
// depends on hrw_pkg
module hrw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  hrw_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output hrw_pkg::t_cmd  o_cmd
);

    logic [5:0] r_state, n_state;
    logic [4:0] r_step, n_step;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            hrw_pkg::OP_IDLE: begin
                if (i_in_valid) n_state = hrw_pkg::OP_PZ2;
            end
            hrw_pkg::OP_G0_INIT, hrw_pkg::OP_G1_INIT: begin
                n_state = r_state + 6'd1;
                n_step  = 5'd30;
            end
            hrw_pkg::OP_W_INIT, hrw_pkg::OP_M_INIT: begin
                n_state = r_state + 6'd1;
                n_step  = 5'd31;
            end
            hrw_pkg::OP_H_INIT: begin
                n_state = r_state + 6'd1;
                n_step  = 5'd16;
            end
            hrw_pkg::OP_RT_INIT: begin
                n_state = r_state + 6'd1;
                n_step  = 5'd23;
            end
            hrw_pkg::OP_G0_DIV, hrw_pkg::OP_G1_DIV, hrw_pkg::OP_W_DIV,
            hrw_pkg::OP_RT_STEP, hrw_pkg::OP_H_DIV, hrw_pkg::OP_M_DIV: begin
                if (r_step == 5'd0) n_state = r_state + 6'd1;
                else n_step = r_step - 5'd1;
            end
            hrw_pkg::OP_ACC: begin
                n_state = i_sts.last ? hrw_pkg::OP_M_INIT : hrw_pkg::OP_OUT;
            end
            hrw_pkg::OP_OUT: begin
                if (!i_sts.out_busy) n_state = hrw_pkg::OP_IDLE;
            end
            hrw_pkg::OP_PZ2, hrw_pkg::OP_DEN_LO, hrw_pkg::OP_DEN_HI, hrw_pkg::OP_N0A,
            hrw_pkg::OP_N0B, hrw_pkg::OP_N1A, hrw_pkg::OP_N1B, hrw_pkg::OP_G0_DONE,
            hrw_pkg::OP_G1_DONE, hrw_pkg::OP_SL_A, hrw_pkg::OP_SL_B, hrw_pkg::OP_SQ,
            hrw_pkg::OP_DD, hrw_pkg::OP_S, hrw_pkg::OP_T_LO, hrw_pkg::OP_T_HI,
            hrw_pkg::OP_DENOM, hrw_pkg::OP_W_DONE, hrw_pkg::OP_WRP, hrw_pkg::OP_H_DONE,
            hrw_pkg::OP_PW, hrw_pkg::OP_RR, hrw_pkg::OP_E_LO, hrw_pkg::OP_E_HI: begin
                n_state = r_state + 6'd1;
            end
            hrw_pkg::OP_M_DONE: n_state = hrw_pkg::OP_OUT;
            default: n_state = hrw_pkg::OP_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrw_pkg::OP_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_ready = (r_state == hrw_pkg::OP_IDLE);
    assign o_cmd.op   = r_state;
    assign o_cmd.load = (r_state == hrw_pkg::OP_IDLE) && i_in_valid;

`ifndef SYNTHESIS
    // an accepted beat starts the sequence on the next cycle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == hrw_pkg::OP_PZ2))
        else $error("sequence did not start after accept");

    // a finished divide moves on to its completion step
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hrw_pkg::OP_W_DIV && r_step == 5'd0)
        |=> (r_state == hrw_pkg::OP_W_DONE))
        else $error("weight divide overran");

    // a stalled result holds the sequencer in the output step
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hrw_pkg::OP_OUT && i_sts.out_busy) |=> (r_state == hrw_pkg::OP_OUT))
        else $error("output step left while result still pending");
`endif

endmodule

// File: tb/huber_residual_weighting_core_tb.sv
// testbench for the huber residual weighting core: random and directed points,
// apb register phases, predicted weights and set means checked beat by beat
// depends on hrw_pkg, hrw_if and huber_residual_weighting_core
module huber_residual_weighting_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_WAIT = 260;
    localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;

    // register indexes
    localparam int unsigned REG_TX = 0;
    localparam int unsigned REG_TY = 1;
    localparam int unsigned REG_TZ = 2;
    localparam int unsigned REG_VGAIN = 3;
    localparam int unsigned REG_HWIDTH = 4;
    localparam int unsigned REG_NOISE = 5;
    localparam int unsigned REG_UNUSED = 7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hrw_in_if in_ch();
    hrw_out_if out_ch();

    huber_residual_weighting_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of registers and set accumulator
    logic [31:0] cfg_tx, cfg_ty, cfg_tz, cfg_vgain, cfg_hwidth, cfg_noise;
    logic [63:0] err_acc;
    logic [19:0] pt_count;

    hrw_pkg::t_item point_queue[$];
    hrw_pkg::t_res weight_queue[$];
    int unsigned fail_count = 0;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned sets_done = 0;
    int unsigned cycle_count = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // num * 2^32 / den, saturated to +-(2^31-1)
    function automatic logic signed [65:0] warp_slope(logic signed [65:0] num,
                                                      logic [127:0] den);
        logic [65:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? -num : num;
        if (mag == 0) return 0;
        if (den == 0) begin
            q = 128'h7FFF_FFFF;
        end else begin
            q = (128'(mag) << 32) / den;
            if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        end
        return (num < 0) ? -$signed({1'b0, q[64:0]}) : $signed({1'b0, q[64:0]});
    endfunction

    // expected result beat for one point, advances the set accumulator
    function automatic hrw_pkg::t_res predict_weight(hrw_pkg::t_item it);
        logic signed [65:0] txw, tyw, tzw, pxw, pyw, pzw, gxw, gyw, n0, n1, g0, g1, sl;
        logic [65:0] smag;
        logic [63:0] pz2, sq, dd, s, t, wp, root, rmag, wrp, h, wh, pw, term;
        logic [64:0] denom, esum;
        logic [127:0] den, tw, ew;
        logic [63:0] rw;
        hrw_pkg::t_res r;
        txw = $signed(cfg_tx);
        tyw = $signed(cfg_ty);
        tzw = $signed(cfg_tz);
        pxw = it.point_x;
        pyw = it.point_y;
        pzw = it.point_z;
        gxw = it.grad_x;
        gyw = it.grad_y;
        // depth derivative of the warp
        pz2 = 64'(pzw * pzw);
        den = 128'(pz2) * 128'(it.inv_depth);
        n0 = txw * pzw - tzw * pxw;
        n1 = tyw * pzw - tzw * pyw;
        g0 = warp_slope(n0, den);
        g1 = warp_slope(n1, den);
        // projected slope, squared in q32.32
        sl = gxw * g0 + gyw * g1;
        smag = (sl < 0) ? -sl : sl;
        sq = 64'(smag >> 16);
        if ((smag >> 16) > 66'(SAT32)) sq = SAT32;
        dd = sq * sq;
        // variance weight
        s = (64'(cfg_vgain) * 64'(it.depth_variance)) >> 16;
        if (s > SAT32) s = SAT32;
        tw = 128'(s) * 128'(dd);
        t = (tw[127:96] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : tw[95:32];
        denom = 65'(t) + 65'(cfg_noise);
        if (denom[64]) denom = 65'h0_FFFF_FFFF_FFFF_FFFF;
        if (denom == 0) begin
            wp = SAT32;
        end else begin
            wp = 64'(65'h1_0000_0000 / denom);
            if (wp > SAT32) wp = SAT32;
        end
        // huber factor on the weighted residual
        root = int_sqrt(wp << 16);
        rw = 64'(it.residual);
        if (it.residual < 0) rw = {32'hFFFF_FFFF, it.residual};
        rmag = ($signed(rw) < 0) ? -rw : rw;
        wrp = (rmag * root) >> 16;
        h = 64'(cfg_hwidth >> 1);
        if (wrp < h) wh = 64'd65536;
        else if (wrp == 0) wh = 0;
        else wh = (h << 16) / wrp;
        pw = ((wh * wp) >> 16) & SAT32;
        // error accumulation
        ew = 128'(pw) * 128'(rmag * rmag);
        term = ew[95:32];
        esum = 65'(err_acc) + 65'(term);
        err_acc = esum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : esum[63:0];
        if (pt_count < hrw_pkg::MAX_POINTS) pt_count = pt_count + 20'd1;
        r.point_weight = pw[31:0];
        r.mean_error = '0;
        r.set_done = it.last_point;
        if (it.last_point) begin
            t = err_acc / 64'(pt_count);
            r.mean_error = (t > SAT32) ? 32'hFFFF_FFFF : t[31:0];
            err_acc = 0;
            pt_count = 0;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] spread(int unsigned m);
        return $signed($urandom_range(0, 2 * m)) - $signed(m);
    endfunction

    function automatic hrw_pkg::t_item random_point();
        hrw_pkg::t_item it;
        if ($urandom_range(0, 9) < 2) begin
            it.point_x = $urandom;
            it.point_y = $urandom;
            it.point_z = $urandom;
            it.inv_depth = 31'($urandom);
            it.residual = $urandom;
            it.grad_x = $urandom;
            it.grad_y = $urandom;
            it.depth_variance = 31'($urandom);
        end else begin
            it.point_x = spread(8 << 16);
            it.point_y = spread(8 << 16);
            it.point_z = $urandom_range(1 << 14, 16 << 16);
            it.inv_depth = 31'($urandom_range(1 << 12, 4 << 16));
            it.residual = spread(50 << 16);
            it.grad_x = spread(200 << 16);
            it.grad_y = spread(200 << 16);
            it.depth_variance = 31'($urandom_range(0, 1 << 16));
            if ($urandom_range(0, 15) == 0) it.point_z = 0;
            if ($urandom_range(0, 15) == 0) it.residual = 0;
        end
        it.last_point = ($urandom_range(0, 11) == 0);
        return it;
    endfunction

    function automatic hrw_pkg::t_item make_point(logic [31:0] px, logic [31:0] py,
            logic [31:0] pz, logic [31:0] d, logic [31:0] rp, logic [31:0] gx,
            logic [31:0] gy, logic [31:0] v, logic lp);
        hrw_pkg::t_item it;
        it.point_x = px;
        it.point_y = py;
        it.point_z = pz;
        it.inv_depth = d[30:0];
        it.residual = rp;
        it.grad_x = gx;
        it.grad_y = gy;
        it.depth_variance = v[30:0];
        it.last_point = lp;
        return it;
    endfunction

    task automatic write_reg(int unsigned idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TX:     cfg_tx = val;
            REG_TY:     cfg_ty = val;
            REG_TZ:     cfg_tz = val;
            REG_VGAIN:  cfg_vgain = val;
            REG_HWIDTH: cfg_hwidth = val;
            REG_NOISE:  cfg_noise = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                             logic [31:0] vg, logic [31:0] hw, logic [31:0] nz);
        write_reg(REG_TX, tx);
        write_reg(REG_TY, ty);
        write_reg(REG_TZ, tz);
        write_reg(REG_VGAIN, vg);
        write_reg(REG_HWIDTH, hw);
        write_reg(REG_NOISE, nz);
    endtask

    task automatic wait_drained();
        while (point_queue.size() != 0 || in_ch.valid || weight_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic queue_random(int unsigned n);
        repeat (n) point_queue.push_back(random_point());
    endtask

    // point driver: beats leave the queue, idle bursts between them
    int unsigned src_gap = 0;
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                weight_queue.push_back(predict_weight(point_queue.pop_front()));
                beats_in++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                offer = 1'b1;
            end else if (src_gap != 0) begin
                src_gap--;
                offer = 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(0, 2);
                offer = 1'b0;
            end else begin
                offer = (point_queue.size() != 0);
            end
            in_ch.valid <= offer;
            if (offer) begin
                in_ch.point_x <= point_queue[0].point_x;
                in_ch.point_y <= point_queue[0].point_y;
                in_ch.point_z <= point_queue[0].point_z;
                in_ch.inv_depth <= point_queue[0].inv_depth;
                in_ch.residual <= point_queue[0].residual;
                in_ch.grad_x <= point_queue[0].grad_x;
                in_ch.grad_y <= point_queue[0].grad_y;
                in_ch.depth_variance <= point_queue[0].depth_variance;
                in_ch.last_point <= point_queue[0].last_point;
            end
        end
    end

    // result monitor and receiver stalls, one long hold-off on request
    int unsigned sink_gap = 0;
    int unsigned hold_cnt = 0;
    bit hold_used = 1'b0;
    always @(posedge i_clk) begin
        hrw_pkg::t_res want;
        logic rdy;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                beats_out++;
                if (weight_queue.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    want = weight_queue.pop_front();
                    if (out_ch.point_weight !== want.point_weight) begin
                        $error("point_weight expected %h actual %h",
                               want.point_weight, out_ch.point_weight);
                        fail_count++;
                    end
                    if (out_ch.mean_error !== want.mean_error) begin
                        $error("mean_error expected %h actual %h",
                               want.mean_error, out_ch.mean_error);
                        fail_count++;
                    end
                    if (out_ch.set_done !== want.set_done) begin
                        $error("set_done expected %b actual %b",
                               want.set_done, out_ch.set_done);
                        fail_count++;
                    end
                    if (want.set_done) sets_done++;
                end
            end
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_cnt = 1500;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                rdy = 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 2);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ch.ready <= rdy;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.point_z = '0;
        in_ch.inv_depth = '0;
        in_ch.residual = '0;
        in_ch.grad_x = '0;
        in_ch.grad_y = '0;
        in_ch.depth_variance = '0;
        in_ch.last_point = 1'b0;
        out_ch.ready = 1'b0;
        cfg_tx = 0;
        cfg_ty = 0;
        cfg_tz = 0;
        cfg_vgain = 32'd65536;
        cfg_hwidth = 32'd655360;
        cfg_noise = 32'd65536;
        err_acc = 0;
        pt_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults, directed corners
        point_queue.push_back(make_point(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        point_queue.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        point_queue.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        point_queue.push_back(make_point(1 << 16, 2 << 16, 4 << 16, 1 << 15, 3 << 16,
            10 << 16, -(7 << 16), 1 << 12, 1'b1));
        wait_drained();
        write_all(1 << 16, -(1 << 15), 1 << 14, 1 << 16, 4 << 16, 1 << 16);
        // zero depth, zero inverse depth, zero numerator, a short set
        point_queue.push_back(make_point(2 << 16, 3 << 16, 0, 1 << 16, 5 << 16,
            40 << 16, 30 << 16, 1 << 14, 1'b0));
        point_queue.push_back(make_point(2 << 16, 3 << 16, 5 << 16, 0, -(5 << 16),
            -(40 << 16), 30 << 16, 1 << 14, 1'b0));
        point_queue.push_back(make_point(4 << 16, -(2 << 16), 1 << 16, 1 << 16, 1 << 16,
            40 << 16, 30 << 16, 1 << 14, 1'b0));
        point_queue.push_back(make_point(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        point_queue.push_back(make_point(1 << 16, 1 << 16, 1 << 16, 1 << 16, 9 << 16,
            500 << 16, 500 << 16, 1 << 16, 1'b1));
        queue_random(250);
        wait_drained();

        // moderate pose, long receiver hold-off
        write_all(spread(4 << 16), spread(4 << 16), spread(4 << 16),
                  $urandom_range(1 << 14, 4 << 16), $urandom_range(1 << 16, 20 << 16),
                  $urandom_range(1, 4 << 16));
        hold_req = 1'b1;
        queue_random(300);
        wait_drained();

        // top extremes
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        point_queue.push_back(make_point(32'h8000_0000, 32'h7FFF_FFFF, 1 << 16, 1 << 16,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        queue_random(150);
        wait_drained();

        // bottom extremes: no variance gain, zero huber width, least noise
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 1);
        point_queue.push_back(make_point(1 << 16, 1 << 16, 1 << 16, 1 << 16, 0,
            1 << 16, 1 << 16, 1 << 16, 1'b0));
        point_queue.push_back(make_point(1 << 16, 1 << 16, 1 << 16, 1 << 16, 3 << 16,
            1 << 16, 1 << 16, 1 << 16, 1'b1));
        queue_random(150);
        wait_drained();

        // write outside the register map has no effect
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        write_all(spread(2 << 16), spread(2 << 16), spread(1 << 16),
                  $urandom_range(1 << 15, 2 << 16), $urandom_range(2 << 16, 12 << 16),
                  $urandom_range(1 << 12, 2 << 16));
        queue_random(300);
        wait_drained();

        // closing stretch with no idling on either side
        no_idle = 1'b1;
        queue_random(150);
        wait_drained();

        $display("%0d points in, %0d results out, %0d sets closed, %0d cycles",
                 beats_in, beats_out, sets_done, cycle_count);
        $display("register phases: defaults, moderate, top and bottom extremes, unmapped write");
        if (fail_count == 0 && weight_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
